[rtl/dsss_barker_dbpsk_shaper_unit_defines.svh]
// Assertion macros used by the checker file of the DSSS shaper.
// No dependencies; include this file by its bare name.
`ifndef DSSS_BARKER_DBPSK_SHAPER_UNIT_DEFINES_SVH
`define DSSS_BARKER_DBPSK_SHAPER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define DBDS_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// Clocked assertion that is also checked around reset.
`define DBDS_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) \
    else $error(msg);

`endif

[rtl/dbds_pkg.sv]
// Package for the DSSS Barker DBPSK shaper: constants, field widths, codes
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dbds_pkg;

  localparam int SAMPLES_PER_BIT_DEF = 44;
  localparam int TAPS_DEF            = 32;
  localparam int COEF_WIDTH_DEF      = 16;

  localparam int IN_COEF_W = 16;
  localparam int TAP_IDX_W = 6;
  localparam int OUT_W     = 21;
  localparam int ROT_W     = 16;
  localparam int FRAC_BITS = 15;
  localparam int CFG_IDX_W = 1;

  // Barker chips sit every fourth sample; bit k set means chip k is +1 for a one.
  localparam int BARKER_LEN   = 11;
  localparam int CHIP_SPACING = 4;
  localparam int SPACE_SH     = $clog2(CHIP_SPACING);
  localparam logic [BARKER_LEN-1:0] BARKER_POS = 11'b000_1110_1101;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_COEF = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN = 1'b1;

  localparam logic signed [ROT_W-1:0] ROT_COS_RST = 16'sh7FFF;
  localparam logic signed [ROT_W-1:0] ROT_SIN_RST = 16'sh0000;

  typedef struct packed {
    logic coef_we;
    logic clear_dl;
    logic issue;
    logic chip_nz;
    logic chip_neg;
    logic last;
  } dbds_cmd_t;

  typedef struct packed {
    logic advance;
  } dbds_sts_t;

  function automatic logic barker_bit(input logic [3:0] k);
    logic b;
    b = 1'b0;
    if (k < 4'(BARKER_LEN)) b = BARKER_POS[k];
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/dbds_ctrl.sv]
// Controller of the DSSS shaper: accepts input words, keeps the differential
// bit and sequences the samples of one bit. Depends on dbds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbds_ctrl #(
  parameter int SAMPLES_PER_BIT = dbds_pkg::SAMPLES_PER_BIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  input  logic                 in_data_bit,
  input  logic                 in_first_bit,
  output logic                 in_stall,
  output dbds_pkg::dbds_cmd_t  cmd,
  input  dbds_pkg::dbds_sts_t  sts
);
  import dbds_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_BIT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BIT - 1);
  localparam logic [CNT_W-1:0] CHIP_END = CNT_W'(BARKER_LEN * CHIP_SPACING);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             diff_r, diff_nxt;
  logic             chip_slot;

  assign in_stall  = (state_r != ST_IDLE);
  assign chip_slot = (cnt_r[SPACE_SH-1:0] == '0) && (cnt_r < CHIP_END);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    diff_nxt     = diff_r;
    cmd          = '0;
    cmd.chip_nz  = chip_slot;
    cmd.chip_neg = barker_bit(4'(cnt_r >> SPACE_SH)) ^ diff_r;
    cmd.last     = (cnt_r == CNT_LAST);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_COEF) begin
            cmd.coef_we = 1'b1;
          end else begin
            diff_nxt     = diff_r ^ in_data_bit;
            cmd.clear_dl = in_first_bit;
            cnt_nxt      = '0;
            state_nxt    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts.advance) begin
          cmd.issue = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      diff_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      diff_r  <= diff_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/dbds_datapath.sv]
// Datapath of the DSSS shaper: chip delay line, coefficient registers,
// registered adder tree, carrier scaling and result register. Depends on dbds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbds_datapath #(
  parameter int TAPS       = dbds_pkg::TAPS_DEF,
  parameter int COEF_WIDTH = dbds_pkg::COEF_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  dbds_pkg::dbds_cmd_t                       cmd,
  output dbds_pkg::dbds_sts_t                       sts,
  input  logic [dbds_pkg::TAP_IDX_W-1:0]            in_tap_index,
  input  logic signed [dbds_pkg::IN_COEF_W-1:0]     in_coef_value,
  input  logic                                      cfg_we,
  input  logic [dbds_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [dbds_pkg::ROT_W-1:0]                cfg_data,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [dbds_pkg::OUT_W-1:0]         out_i_sample,
  output logic signed [dbds_pkg::OUT_W-1:0]         out_q_sample,
  output logic                                      out_last
);
  import dbds_pkg::*;

  localparam int CSW    = (COEF_WIDTH < IN_COEF_W) ? COEF_WIDTH : IN_COEF_W;
  localparam int SW     = CSW + $clog2(TAPS) + 1;
  localparam int NL     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int NLEAF  = 1 << NL;
  localparam int NODES  = 2 * NLEAF - 1;
  localparam int MW     = SW + ROT_W;
  localparam int KEEP_W = OUT_W + FRAC_BITS;
  localparam int PW     = (MW > KEEP_W) ? MW : KEEP_W;

  logic signed [CSW-1:0]   coef_r [TAPS];
  logic [TAPS-1:0]         nz_r, nz_nxt, neg_r, neg_nxt;
  logic signed [ROT_W-1:0] rot_cos_r, rot_sin_r;
  logic signed [SW-1:0]    leaf_c [NLEAF];
  logic signed [SW-1:0]    node_r [NODES];
  logic [NL-1:0]           vld_r_lo;
  logic [NL:0]             vld_r, last_r;
  logic signed [MW-1:0]    prod_i_c, prod_q_c;
  logic signed [PW-1:0]    prod_i_x, prod_q_x;
  logic                    out_valid_r, out_last_r;
  logic signed [OUT_W-1:0] out_i_r, out_q_r;

  assign sts.advance = !out_valid_r || !out_stall;
  assign vld_r_lo    = vld_r[NL-1:0];

  // Delay line: cleared at the start of a frame, shifted once per sample.
  always_comb begin
    nz_nxt  = nz_r;
    neg_nxt = neg_r;
    if (cmd.clear_dl) begin
      nz_nxt = '0;
    end else if (cmd.issue) begin
      nz_nxt  = TAPS'({nz_r, cmd.chip_nz});
      neg_nxt = TAPS'({neg_r, cmd.chip_neg});
    end
  end

  generate
    for (genvar t = 0; t < NLEAF; t++) begin : g_leaf
      if (t < TAPS) begin : g_tap
        assign leaf_c[t] = !nz_nxt[t] ? '0 :
                           (neg_nxt[t] ? -SW'(coef_r[t]) : SW'(coef_r[t]));
      end else begin : g_pad
        assign leaf_c[t] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int t = 0; t < TAPS; t++) begin
      if (cmd.coef_we && (in_tap_index == TAP_IDX_W'(t))) begin
        coef_r[t] <= in_coef_value[CSW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sts.advance) begin
      for (int n = 0; n < NLEAF - 1; n++) begin
        node_r[n] <= node_r[2*n+1] + node_r[2*n+2];
      end
      for (int t = 0; t < NLEAF; t++) begin
        node_r[NLEAF-1+t] <= leaf_c[t];
      end
    end
  end

  assign prod_i_c = node_r[0] * rot_cos_r;
  assign prod_q_c = node_r[0] * rot_sin_r;
  assign prod_i_x = PW'(prod_i_c);
  assign prod_q_x = PW'(prod_q_c);

  always_ff @(posedge clk) begin
    if (sts.advance) begin
      out_i_r <= prod_i_x[KEEP_W-1:FRAC_BITS];
      out_q_r <= prod_q_x[KEEP_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    if (!rst_n) begin
      nz_r        <= '0;
      vld_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      rot_cos_r   <= ROT_COS_RST;
      rot_sin_r   <= ROT_SIN_RST;
    end else begin
      nz_r <= nz_nxt;
      if (sts.advance) begin
        vld_r       <= {vld_r_lo, cmd.issue};
        last_r      <= {last_r[NL-1:0], cmd.issue && cmd.last};
        out_valid_r <= vld_r[NL];
        out_last_r  <= last_r[NL];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROT_COS: rot_cos_r <= cfg_data;
          REG_ROT_SIN: rot_sin_r <= cfg_data;
          default:     rot_cos_r <= rot_cos_r;
        endcase
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_i_sample = out_i_r;
  assign out_q_sample = out_q_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

[rtl/dsss_barker_dbpsk_shaper_unit.sv]
// Top level of the DSSS Barker DBPSK shaper: joins controller and datapath.
// Depends on dbds_pkg, dbds_ctrl and dbds_datapath.
//
//   Channel   Direction  Handshake           Word contents
//   in_*      input      in_valid/in_stall   kind, data_bit, first_bit, tap_index, coef_value
//   out_*     output     out_valid/out_stall i_sample, q_sample, last
//   cfg_*     input      cfg_valid/cfg_ready cfg_index (0 rot_cos, 1 rot_sin), cfg_data
//
// A data word holds the input channel from its acceptance until the
// controller has stepped its sample counter through the SAMPLES_PER_BIT
// samples of the bit, one sample per cycle while the result side does not stall.
// A coefficient word does not stall the input. The first result of a bit is
// shown after the word is accepted and its first sample is loaded into the delay
// line and the leaf registers, carried up the adder tree and loaded as a
// scaled sum into the result register.
// Reset is synchronous and active low; it needs no clearing pass.
// A stall on the result side freezes the whole sample pipeline, and the
// controller issues no further sample until the result register drains.
`timescale 1ns / 1ps
`default_nettype none

module dsss_barker_dbpsk_shaper_unit #(
  parameter int SAMPLES_PER_BIT = dbds_pkg::SAMPLES_PER_BIT_DEF,
  parameter int TAPS            = dbds_pkg::TAPS_DEF,
  parameter int COEF_WIDTH      = dbds_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input word channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic                                  in_data_bit,
  input  logic                                  in_first_bit,
  input  logic [dbds_pkg::TAP_IDX_W-1:0]        in_tap_index,
  input  logic signed [dbds_pkg::IN_COEF_W-1:0] in_coef_value,
  // Result word channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dbds_pkg::OUT_W-1:0]     out_i_sample,
  output logic signed [dbds_pkg::OUT_W-1:0]     out_q_sample,
  output logic                                  out_last,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dbds_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dbds_pkg::ROT_W-1:0]            cfg_data
);
  import dbds_pkg::*;

  dbds_cmd_t cmd;
  dbds_sts_t sts;

  // Configuration registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller owns the input handshake, the differential bit and the
  // per-sample sequencing, including which samples carry a Barker chip.
  dbds_ctrl #(
    .SAMPLES_PER_BIT (SAMPLES_PER_BIT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_data_bit  (in_data_bit),
    .in_first_bit (in_first_bit),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // The datapath holds the delay line and coefficients, forms the filter sum
  // in a registered tree and scales it by the carrier cosine and sine.
  dbds_datapath #(
    .TAPS       (TAPS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_tap_index  (in_tap_index),
    .in_coef_value (in_coef_value),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_i_sample  (out_i_sample),
    .out_q_sample  (out_q_sample),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

[rtl/dbds_checker.sv]
// Port-level checker for the DSSS shaper and its bind to the top level.
// Depends on dbds_pkg and dsss_barker_dbpsk_shaper_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dsss_barker_dbpsk_shaper_unit_defines.svh"

module dbds_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [dbds_pkg::OUT_W-1:0] out_i_sample,
  input logic signed [dbds_pkg::OUT_W-1:0] out_q_sample,
  input logic                              out_last
);
  import dbds_pkg::*;

  `DBDS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_i_sample) && $stable(out_q_sample) && $stable(out_last), "result word changed while stalled")

  `DBDS_ASSERT(a_data_busy, clk, rst_n, in_valid && !in_stall && (in_kind == KIND_DATA) |=> in_stall, "input taken right after a data word")

  `DBDS_ASSERT(a_coef_free, clk, rst_n, in_valid && !in_stall && (in_kind == KIND_COEF) |=> !in_stall, "input stalled after a coefficient word")

  `DBDS_ASSERT_NR(a_reset_idle, clk, $rose(rst_n) |-> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind dsss_barker_dbpsk_shaper_unit dbds_checker u_dbds_checker (.*);

`default_nettype wire

[dv/tb_dsss_barker_dbpsk_shaper_unit.sv]
// Self-checking testbench for the DSSS Barker DBPSK shaper unit.
// Uses dbds_pkg for widths, codes and the Barker pattern; needs only the RTL.
`timescale 1ns / 1ps

module tb_dsss_barker_dbpsk_shaper_unit;
  import dbds_pkg::*;

  localparam int SPB           = SAMPLES_PER_BIT_DEF;
  localparam int NTAPS         = TAPS_DEF;
  localparam int IDLE_PCT      = 19;
  localparam int SETTLE_CYCLES = 16;   // covers the adder tree plus a late coefficient word
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam logic signed [1:0] CHIP_POS = 2'sb01;
  localparam logic signed [1:0] CHIP_NEG = 2'sb11;

  typedef struct packed {
    logic signed [OUT_W-1:0] i_val;
    logic signed [OUT_W-1:0] q_val;
    logic                    is_last;
  } shaped_sample_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_DATA;
  logic in_data_bit = 1'b0;
  logic in_first_bit = 1'b0;
  logic [TAP_IDX_W-1:0] in_tap_index = '0;
  logic signed [IN_COEF_W-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_i_sample;
  logic signed [OUT_W-1:0] out_q_sample;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROT_COS;
  logic [ROT_W-1:0] cfg_data = '0;

  // Shadow copy of the modulator state, kept in step with accepted words.
  logic                    diff_state = 1'b0;
  logic signed [1:0]       chip_line [NTAPS];
  logic signed [15:0]      coef_shadow [NTAPS];
  logic signed [ROT_W-1:0] rot_cos_shadow = ROT_COS_RST;
  logic signed [ROT_W-1:0] rot_sin_shadow = ROT_SIN_RST;

  // Samples predicted but not yet seen on the result channel, oldest first.
  shaped_sample_t expected_samples [$];
  shaped_sample_t want;

  int unsigned mismatch_count = 0;
  int unsigned samples_checked = 0;
  int unsigned bits_sent = 0;
  int unsigned coef_writes = 0;
  int unsigned coef_ignored = 0;
  int unsigned rot_settings = 0;
  int unsigned cycle_count = 0;

  // Idling control shared by the sender and the result-side stall process.
  bit quiet_mode = 1'b0;
  int hold_request = 0;
  int hold_left = 0;

  dsss_barker_dbpsk_shaper_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_bit  (in_data_bit),
    .in_first_bit (in_first_bit),
    .in_tap_index (in_tap_index),
    .in_coef_value(in_coef_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_i_sample (out_i_sample),
    .out_q_sample (out_q_sample),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int t = 0; t < NTAPS; t++) begin
      chip_line[t] = '0;
      coef_shadow[t] = '0;
    end
  end

  // Every mismatch goes through here: one line each, and it is counted.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch %0d: %s", $realtime, mismatch_count, msg);
  endtask

  // Works out the SPB shaped samples of one data bit. The bit is first
  // encoded against the kept differential bit; the encoded bit sets the chip
  // polarity, and each Barker chip lands on every fourth sample slot. A
  // first-of-frame bit empties the delay line but keeps the differential bit.
  task automatic shape_bit(input logic data, input logic first);
    logic signed [1:0] chip;
    longint acc;
    longint prod_i;
    longint prod_q;
    shaped_sample_t s;
    int k;
    diff_state = diff_state ^ data;
    if (first) begin
      for (int t = 0; t < NTAPS; t++) chip_line[t] = '0;
    end
    for (int j = 0; j < SPB; j++) begin
      chip = '0;
      k = j / CHIP_SPACING;
      if ((j % CHIP_SPACING) == 0 && k < BARKER_LEN) begin
        // A chip is +1 when the Barker position agrees with the encoded bit.
        chip = (BARKER_POS[k] == diff_state) ? CHIP_POS : CHIP_NEG;
      end
      for (int t = NTAPS - 1; t > 0; t--) chip_line[t] = chip_line[t-1];
      chip_line[0] = chip;
      acc = 0;
      for (int t = 0; t < NTAPS; t++) begin
        acc += longint'(chip_line[t]) * longint'(coef_shadow[t]);
      end
      // Arithmetic shift gives the floor, as the rotator truncates.
      prod_i = (acc * longint'(rot_cos_shadow)) >>> FRAC_BITS;
      prod_q = (acc * longint'(rot_sin_shadow)) >>> FRAC_BITS;
      s.i_val = prod_i[OUT_W-1:0];
      s.q_val = prod_q[OUT_W-1:0];
      s.is_last = (j == SPB - 1);
      expected_samples.push_back(s);
    end
  endtask

  // Offers one word and returns in the time step it is accepted. The valid
  // line stays high on return; the caller either offers the next word in the
  // same step or drops valid with end_burst.
  task automatic send_word(input logic kind, input logic data, input logic first,
                           input logic [TAP_IDX_W-1:0] tap,
                           input logic signed [IN_COEF_W-1:0] coef);
    if (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_data_bit   <= data;
    in_first_bit  <= first;
    in_tap_index  <= tap;
    in_coef_value <= coef;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_COEF) begin
      coef_writes++;
      if (tap < NTAPS) coef_shadow[tap] = coef;
      else coef_ignored++;
    end else begin
      bits_sent++;
      shape_bit(data, first);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted sample has come back, then lets the pipeline
  // settle so a trailing coefficient word has surely landed.
  task automatic drain_block();
    end_burst();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both rotation registers back to back; only called while idle.
  task automatic set_rotation(input logic [ROT_W-1:0] cos_v, input logic [ROT_W-1:0] sin_v);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROT_COS;
    cfg_data  <= cos_v;
    do @(posedge clk); while (!cfg_ready);
    rot_cos_shadow = cos_v;
    cfg_index <= REG_ROT_SIN;
    cfg_data  <= sin_v;
    do @(posedge clk); while (!cfg_ready);
    rot_sin_shadow = sin_v;
    cfg_valid <= 1'b0;
    rot_settings++;
  endtask

  task automatic send_random_word();
    logic kind;
    logic [TAP_IDX_W-1:0] tap;
    kind = ($urandom_range(99) < 20) ? KIND_COEF : KIND_DATA;
    tap = TAP_IDX_W'($urandom_range(63));
    // Keep most coefficient writes inside the table so the shape keeps changing.
    if (kind == KIND_COEF && $urandom_range(99) < 80) begin
      tap = TAP_IDX_W'($urandom_range(NTAPS - 1));
    end
    send_word(kind, 1'($urandom_range(1)), $urandom_range(99) < 8, tap,
              IN_COEF_W'($urandom));
  endtask

  // Fills the whole coefficient table before any bit reads it.
  task automatic test_coef_load();
    for (int t = 0; t < NTAPS; t++) begin
      send_word(KIND_COEF, 1'($urandom_range(1)), 1'($urandom_range(1)), TAP_IDX_W'(t),
                IN_COEF_W'($urandom));
    end
    end_burst();
  endtask

  // Differential encoding, frame starts, ignored table writes and the
  // coefficient extremes, all at the reset rotation.
  task automatic test_special_cases();
    send_word(KIND_DATA, 1'b1, 1'b1, 6'd63, 16'sh8000);
    send_word(KIND_DATA, 1'b0, 1'b0, 6'd0, 16'sh7FFF);
    send_word(KIND_DATA, 1'b1, 1'b0, 6'd21, 16'sh5555);
    // A frame start must clear only the delay line, not the encoder bit.
    send_word(KIND_DATA, 1'b1, 1'b1, 6'd42, 16'shAAAA);
    // Writes past the end of the table must leave it untouched.
    send_word(KIND_COEF, 1'b1, 1'b1, 6'd63, 16'sh7FFF);
    send_word(KIND_COEF, 1'b0, 1'b1, TAP_IDX_W'(NTAPS), 16'sh8000);
    send_word(KIND_DATA, 1'b0, 1'b0, 6'd5, 16'sh0001);
    send_word(KIND_COEF, 1'b1, 1'b0, 6'd0, 16'sh8000);
    send_word(KIND_COEF, 1'b0, 1'b0, TAP_IDX_W'(NTAPS - 1), 16'sh7FFF);
    send_word(KIND_DATA, 1'b1, 1'b0, 6'd0, 16'sh0000);
    end_burst();
  endtask

  // Rotation register extremes, each with a few bits.
  task automatic test_rotation_extremes();
    logic [ROT_W-1:0] cos_set [3];
    logic [ROT_W-1:0] sin_set [3];
    cos_set = '{16'h8000, 16'h7FFF, 16'h0000};
    sin_set = '{16'h7FFF, 16'h8000, 16'h0000};
    for (int p = 0; p < 3; p++) begin
      drain_block();
      set_rotation(cos_set[p], sin_set[p]);
      for (int n = 0; n < 3; n++) begin
        send_word(KIND_DATA, 1'($urandom_range(1)), n == 0, TAP_IDX_W'($urandom_range(63)),
                  IN_COEF_W'($urandom));
      end
    end
    end_burst();
  endtask

  // Random words over several rotation settings; one phase runs with no
  // idling on either side.
  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      drain_block();
      set_rotation(ROT_W'($urandom), ROT_W'($urandom));
      quiet_mode = (p == 2);
      for (int n = 0; n < 100; n++) send_random_word();
      end_burst();
      quiet_mode = 1'b0;
    end
  endtask

  // The result side holds off for a long stretch while words keep coming,
  // so the sample pipeline fills and the input channel has to stall.
  task automatic test_backpressure();
    drain_block();
    quiet_mode = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 12; n++) begin
      send_word(KIND_DATA, 1'($urandom_range(1)), 1'b0, TAP_IDX_W'($urandom_range(63)),
                IN_COEF_W'($urandom));
    end
    end_burst();
    quiet_mode = 1'b0;
  endtask

  // Result-side stall: a long hold when asked for, otherwise random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result checker: every accepted sample is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample with nothing expected: i=%0d q=%0d last=%0b",
                                  out_i_sample, out_q_sample, out_last));
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (out_i_sample !== want.i_val) begin
          report_mismatch($sformatf("i_sample %0d, wanted %0d", out_i_sample, want.i_val));
        end
        if (out_q_sample !== want.q_val) begin
          report_mismatch($sformatf("q_sample %0d, wanted %0d", out_q_sample, want.q_val));
        end
        if (out_last !== want.is_last) begin
          report_mismatch($sformatf("last %0b, wanted %0b", out_last, want.is_last));
        end
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d samples still expected",
             cycle_count, expected_samples.size());
    $display("FAIL dsss_barker_dbpsk_shaper_unit");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_coef_load();
    test_special_cases();
    test_rotation_extremes();
    test_random_traffic();
    test_backpressure();
    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
    end
    $display("Run covered %0d data bits and %0d coefficient words (%0d past the table end)",
             bits_sent, coef_writes, coef_ignored);
    $display("over %0d rotation settings; %0d samples checked, %0d mismatches.",
             rot_settings, samples_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS dsss_barker_dbpsk_shaper_unit");
    end else begin
      $display("FAIL dsss_barker_dbpsk_shaper_unit");
    end
    $finish;
  end

endmodule
